@@ hdl/sbge_pkg.sv @@
package sbge_pkg;

    // bytes in one full group, bytes held while a group is collected
    localparam int GROUP_MAX   = 4;
    localparam int HOLD_DEPTH  = GROUP_MAX - 1;
    localparam int BYTE_W      = 8;
    localparam int SEVEN_W     = 7;

    // group queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // position of a byte inside a group
    typedef logic [1:0] grp_idx_t;

    // one classified group, ready to be sent
    typedef struct packed {
        logic [SEVEN_W-1:0]                header;
        logic [GROUP_MAX-1:0][SEVEN_W-1:0] low_bits;
        grp_idx_t                          last_idx;
        logic                              msg_last;
    } sbge_group_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } sbge_qstat_t;

endpackage

@@ hdl/sbge_front.sv @@
module sbge_front
    import sbge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  sbge_qstat_t       q_stat,
    output logic              push,
    output sbge_group_t       push_group
);

    logic [BYTE_W-1:0] held_bytes_reg [HOLD_DEPTH];
    grp_idx_t          held_count_reg;
    grp_idx_t          held_count_next;

    logic [BYTE_W-1:0] held_view [GROUP_MAX];
    logic [BYTE_W-1:0] grp       [GROUP_MAX];
    logic [2:0]        grp_size;
    logic              accept;
    logic              flush;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    // group closes on the message end or on its fourth byte
    assign flush    = s_tlast || (held_count_reg == grp_idx_t'(HOLD_DEPTH));
    assign push     = accept && flush;
    assign grp_size = {1'b0, held_count_reg} + 3'd1;

    always_comb
    begin
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            held_view[i] = held_bytes_reg[i];
        end
        held_view[GROUP_MAX-1] = '0;
        for (int i = 0; i < GROUP_MAX; i++)
        begin
            if (i == int'(held_count_reg))
            begin
                grp[i] = s_tdata;
            end
            else if (i < int'(held_count_reg))
            begin
                grp[i] = held_view[i];
            end
            else
            begin
                grp[i] = '0;
            end
        end
    end

    always_comb
    begin
        push_group.header = {grp_size, grp[0][BYTE_W-1], grp[1][BYTE_W-1],
                             grp[2][BYTE_W-1], grp[3][BYTE_W-1]};
        for (int i = 0; i < GROUP_MAX; i++)
        begin
            push_group.low_bits[i] = grp[i][SEVEN_W-1:0];
        end
        push_group.last_idx = held_count_reg;
        push_group.msg_last = s_tlast;
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        if (accept)
        begin
            held_count_next = flush ? '0 : held_count_reg + grp_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
        end
        else
        begin
            held_count_reg <= held_count_next;
        end
    end

    // held bytes carry no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (accept && !flush)
        begin
            held_bytes_reg[held_count_reg] <= s_tdata;
        end
    end

endmodule

@@ hdl/sbge_queue.sv @@
module sbge_queue
    import sbge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sbge_group_t push_group,
    input  logic        pop,
    output sbge_group_t pop_group,
    output sbge_qstat_t q_stat
);

    sbge_group_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QFILL_W-1:0]  fill_reg;
    logic [QFILL_W-1:0]  fill_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_group    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QFILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QFILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

endmodule

@@ hdl/sbge_back.sv @@
module sbge_back
    import sbge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbge_group_t       pop_group,
    input  sbge_qstat_t       q_stat,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    logic [2:0]         idx_m1;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [SEVEN_W-1:0] out_byte_reg;
    logic               gend_reg;
    logic               mend_reg;

    logic               load;
    logic               emit;
    logic               gend;
    logic [SEVEN_W-1:0] cur_byte;

    // output register takes a new word when empty or being drained
    assign load   = !m_tvalid_reg || m_tready;
    assign emit   = load && !q_stat.empty;
    assign idx_m1 = idx_reg - 3'd1;
    assign gend   = (idx_reg == ({1'b0, pop_group.last_idx} + 3'd1));
    assign pop    = emit && gend;

    // header first, then the low seven bits of each byte
    assign cur_byte = (idx_reg == '0) ? pop_group.header
                                      : pop_group.low_bits[idx_m1[1:0]];

    always_comb
    begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            m_tvalid_next = !q_stat.empty;
        end
        if (emit)
        begin
            idx_next = gend ? '0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            gend_reg     <= gend;
            mend_reg     <= gend && pop_group.msg_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_byte_reg};
    assign m_tlast  = gend_reg;
    assign m_tuser  = mend_reg;

endmodule

@@ hdl/seven_bit_group_encoder_top.sv @@
// output path: a byte that closes a group is written into the group queue; its header
//   word then reaches m_tdata via the output register, the rest one word per cycle
// throughput: one output word per cycle from the single output register; a full group of
//   four input bytes gives five words; words stall while m_tready is low
// reset: rst_n clears counts, queue pointers and output valid; held bytes are not cleared
module seven_bit_group_encoder_top
    import sbge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] out_byte, [7] zero
    output logic        m_tlast,   // group_end
    output logic        m_tuser    // message_end
);

    sbge_qstat_t q_stat;
    sbge_group_t push_group;
    sbge_group_t pop_group;
    logic        push;
    logic        pop;

    // front: holds up to three bytes and builds a group of up to four with its header
    sbge_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_group (push_group)
    );

    // short group queue so collecting and sending stall independently
    sbge_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .pop_group  (pop_group),
        .q_stat     (q_stat)
    );

    // back: walks a group out word by word through the output register
    sbge_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_group (pop_group),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hdl/sbge_checker.sv @@
module sbge_port_props
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // next output word opens a group
    logic expect_header_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
        end
        else if (m_tvalid && m_tready)
        begin
            expect_header_reg <= m_tlast;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_msg_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("message end outside group end");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && expect_header_reg |-> !m_tlast && !m_tuser && !m_tdata[7]
            && (m_tdata[6:4] == 3'd1 || m_tdata[6:4] == 3'd2
                || m_tdata[6:4] == 3'd3 || m_tdata[6:4] == 3'd4))
        else $error("bad group header word");

endmodule

bind seven_bit_group_encoder_top sbge_port_props u_sbge_port_props (.*);

@@ bench/sbge_checker.sv @@
`timescale 1ns / 100ps

module sbge_checker
    import sbge_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [6:0] out_byte, [7] zero
    input  logic       m_tlast,   // group_end
    input  logic       m_tuser,   // message_end
    output int         errors,
    output int         pending
);

    typedef struct packed {
        logic [SEVEN_W-1:0] code;
        logic               group_end;
        logic               message_end;
    } enc_word_t;

    enc_word_t         expected_words[$];
    enc_word_t         want_word;
    logic [BYTE_W-1:0] held[HOLD_DEPTH];
    int                held_n     = 0;
    int                words_seen = 0;
    int                fail_count = 0;
    int                pending_r  = 0;

    assign errors  = fail_count;
    assign pending = pending_r;

    task automatic report(input string what, input int got, input int want);
        $display("word %0d: %s got %0h want %0h", words_seen, what, got, want);
        fail_count++;
    endtask

    // hold bytes until a group closes, then queue header and payload words
    task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [BYTE_W-1:0] grp[GROUP_MAX];
        int                size;
        enc_word_t         w;
        if (!last && held_n < HOLD_DEPTH) begin
            held[held_n] = b;
            held_n++;
            return;
        end
        for (int i = 0; i < held_n; i++)
            grp[i] = held[i];
        grp[held_n] = b;
        size = held_n + 1;
        w.code = SEVEN_W'(size << 4);
        for (int i = 0; i < size; i++)
            w.code[3 - i] = grp[i][7];
        w.group_end   = 1'b0;
        w.message_end = 1'b0;
        expected_words.push_back(w);
        for (int i = 0; i < size; i++) begin
            w.code        = grp[i][SEVEN_W-1:0];
            w.group_end   = (i == size - 1);
            w.message_end = (i == size - 1) && last;
            expected_words.push_back(w);
        end
        held_n = 0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_n = 0;
            expected_words.delete();
            pending_r <= 0;
        end
        else begin
            // outputs first; a byte taken at this edge cannot show up yet
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report("word with nothing pending", m_tdata, 0);
                end
                else begin
                    want_word = expected_words.pop_front();
                    if (m_tdata[SEVEN_W-1:0] !== want_word.code)
                        report("out_byte", m_tdata[SEVEN_W-1:0], want_word.code);
                    if (m_tdata[7] !== 1'b0)
                        report("tdata pad bit", m_tdata[7], 0);
                    if (m_tlast !== want_word.group_end)
                        report("group_end", m_tlast, want_word.group_end);
                    if (m_tuser !== want_word.message_end)
                        report("message_end", m_tuser, want_word.message_end);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            pending_r <= expected_words.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import sbge_pkg::*;

    // random bytes after the directed part
    localparam int RANDOM_BYTES = 145;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;    // [7:0] data_byte
    logic       s_tlast  = 1'b0;  // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [6:0] out_byte, [7] zero
    logic       m_tlast;          // group_end
    logic       m_tuser;          // message_end

    // calm phases: no idling on that side
    logic       tx_calm  = 1'b0;
    logic       rx_calm  = 1'b0;

    int         errors;
    int         pending;
    int         sent     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    seven_bit_group_encoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sbge_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // present one word and hold it until taken, then maybe idle
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending until every predicted word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: ready runs broken by stalls of random length
    initial
    begin
        int run;
        int stall;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = rx_calm ? 0 : pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int         base;
        int         len;
        int         r;
        logic [7:0] b;
        logic       paused;

        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte messages at both extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two and three byte partial groups flushed by the last byte
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b1);
        // full group that also ends the message, all top bits set
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        // full group without message end, then a lone last byte
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b1);
        // group of four followed by a group of three
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b1);
        drain();

        // random messages, mostly short, some spanning several groups
        base = sent;
        while (sent - base < RANDOM_BYTES)
        begin
            // middle stretch runs with no idling on either side
            tx_calm <= (sent - base >= 60) && (sent - base < 110);
            rx_calm <= (sent - base >= 60) && (sent - base < 110);
            if (!paused && sent - base >= 85)
            begin
                drain();
                paused = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                              : $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
            begin
                // bias toward the values where bit 7 and the low bits flip
                r = $urandom_range(0, 7);
                case (r)
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    2:       b = 8'h7F;
                    3:       b = 8'h80;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, i == len - 1);
            end
        end

        // let the pipeline empty, then watch for stray words
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
